### hw/rtl/battery_level_gauge_defines.svh
// ---------------------------------------------------------------------------
// battery_level_gauge_defines
// Assertion macros shared by the battery level gauge modules. Both macros
// sample on clk_i and are disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_GAUGE_DEFINES_SVH
`define BATTERY_LEVEL_GAUGE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BLG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BLG_ASSERT_IMP(lbl, ante, cons, msg)
`define BLG_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### hw/rtl/blg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blg_pkg
// Widths, constants, discharge curve and controller types of the battery
// level gauge.
// ---------------------------------------------------------------------------
package blg_pkg;

  localparam int ADC_W        = 12;
  localparam int SCALE_W      = 18;
  localparam int SCALE_FRAC   = 16;
  localparam int MV_W         = 13;
  localparam int PCT_W        = 7;
  localparam int SAMPLES      = 5;
  localparam int TABLE_POINTS = 21;
  localparam int SUM_W        = 15;
  localparam int CNT_W        = 3;
  localparam int IDX_W        = $clog2(TABLE_POINTS);

  localparam logic [SCALE_W-1:0] SCALE_RESET = 18'd93446;

  // truncated mean by multiply with a rounded-up reciprocal, exact for any sum
  localparam int MEAN_SHIFT  = SUM_W + $clog2(SAMPLES);
  localparam int MEAN_RECIP  = ((1 << MEAN_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int RECIP_W     = MEAN_SHIFT + 1;
  localparam int MEAN_PROD_W = SUM_W + RECIP_W;

  localparam int SCALE_PROD_W = ADC_W + SCALE_W;
  localparam int MV_WIDE_W    = SCALE_PROD_W - SCALE_FRAC;

  // interpolation divide: quotient never exceeds one step of the curve
  localparam int NUM_W  = PCT_W + MV_W;
  localparam int QBITS  = PCT_W;
  localparam int QCNT_W = $clog2(QBITS);

  localparam logic [MV_W-1:0]  MV_MAX   = {MV_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_NONE = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [MV_W-1:0] CURVE_MV [TABLE_POINTS] = '{
    13'd3270, 13'd3610, 13'd3690, 13'd3710, 13'd3730, 13'd3750, 13'd3770,
    13'd3790, 13'd3800, 13'd3820, 13'd3840, 13'd3850, 13'd3870, 13'd3910,
    13'd3950, 13'd3980, 13'd4020, 13'd4080, 13'd4110, 13'd4150, 13'd4200
  };

  localparam logic [PCT_W-1:0] CURVE_PCT [TABLE_POINTS] = '{
    7'd0,  7'd5,  7'd10, 7'd15, 7'd20, 7'd25, 7'd30,
    7'd35, 7'd40, 7'd45, 7'd50, 7'd55, 7'd60, 7'd65,
    7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_SCALE,
    ST_SCAN,
    ST_PRODUCT,
    ST_DIVIDE,
    ST_EMIT
  } blg_state_e;

  typedef struct packed {
    logic accept;
    logic mean;
    logic scale;
    logic scan;
    logic product;
    logic divide;
    logic emit;
  } blg_cmd_t;

  typedef struct packed {
    logic group_last;
    logic mv_low;
    logic mv_high;
    logic scan_hit;
    logic div_last;
  } blg_stat_t;

endpackage

### hw/rtl/blg_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blg_if
// Valid/ready channels of the battery level gauge: sample in, result out.
// ---------------------------------------------------------------------------
interface blg_in_if;
  logic                     valid;
  logic                     ready;
  logic [blg_pkg::ADC_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

interface blg_out_if;
  logic                      valid;
  logic                      ready;
  logic [blg_pkg::MV_W-1:0]  battery_mv;
  logic [blg_pkg::PCT_W-1:0] charge_percent;

  modport source (output valid, output battery_mv, output charge_percent, input ready);
  modport sink (input valid, input battery_mv, input charge_percent, output ready);
endinterface

### hw/rtl/blg_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blg_ctrl
// Sequencer of the gauge: takes samples, walks a finished group through mean,
// scaling, curve scan and, off the curve ends, product and divide, and owns the result valid flag.
// ---------------------------------------------------------------------------
`include "battery_level_gauge_defines.svh"

module blg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  blg_pkg::blg_stat_t stat_i,
  output blg_pkg::blg_cmd_t  cmd_o
);

  blg_pkg::blg_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= blg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      blg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.group_last) state_d = blg_pkg::ST_MEAN;
        end
      end
      blg_pkg::ST_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d    = blg_pkg::ST_SCALE;
      end
      blg_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = blg_pkg::ST_SCAN;
      end
      blg_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.mv_low || stat_i.mv_high) begin
          state_d = blg_pkg::ST_EMIT;
        end else if (stat_i.scan_hit) begin
          state_d = blg_pkg::ST_PRODUCT;
        end
      end
      blg_pkg::ST_PRODUCT: begin
        cmd_o.product = 1'b1;
        state_d       = blg_pkg::ST_DIVIDE;
      end
      blg_pkg::ST_DIVIDE: begin
        cmd_o.divide = 1'b1;
        if (stat_i.div_last) state_d = blg_pkg::ST_EMIT;
      end
      blg_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = blg_pkg::ST_IDLE;
        end
      end
      default: state_d = blg_pkg::ST_IDLE;
    endcase
  end

  // a loaded word replaces a taken one, otherwise valid holds until taken
  assign out_valid_d = cmd_o.emit || (out_valid_q && !out_ready_i);

  `BLG_ASSERT_NXT(a_last_sample_starts_mean, in_valid_i && in_ready_o && stat_i.group_last, state_q == blg_pkg::ST_MEAN, "last sample of a group did not start the mean")
  `BLG_ASSERT_NXT(a_divide_ends_in_emit, state_q == blg_pkg::ST_DIVIDE && stat_i.div_last, state_q == blg_pkg::ST_EMIT, "divide did not finish into emit")
  `BLG_ASSERT_NXT(a_emit_raises_valid, cmd_o.emit, out_valid_q && state_q == blg_pkg::ST_IDLE, "emitted word not presented")

endmodule

### hw/rtl/blg_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blg_datapath
// Sample accumulator, reciprocal mean, Q16 millivolt scaling with
// saturation, curve scan and restoring divide for the interpolation.
// ---------------------------------------------------------------------------
`include "battery_level_gauge_defines.svh"

module blg_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [blg_pkg::SCALE_W-1:0] cfg_wdata_i,
  input  logic [blg_pkg::ADC_W-1:0]   adc_sample_i,
  input  blg_pkg::blg_cmd_t           cmd_i,
  output blg_pkg::blg_stat_t          stat_o,
  output logic [blg_pkg::MV_W-1:0]    battery_mv_o,
  output logic [blg_pkg::PCT_W-1:0]   charge_percent_o
);

  logic [blg_pkg::SCALE_W-1:0] scale_q;
  logic [blg_pkg::SUM_W-1:0]   sum_q;
  logic [blg_pkg::CNT_W-1:0]   count_q;

  logic [blg_pkg::ADC_W-1:0]  mean_q;
  logic [blg_pkg::MV_W-1:0]   mv_q;
  logic [blg_pkg::IDX_W-1:0]  idx_q;
  logic [blg_pkg::NUM_W-1:0]  rem_q;
  logic [blg_pkg::NUM_W-1:0]  div_q;
  logic [blg_pkg::QBITS-1:0]  quot_q;
  logic [blg_pkg::QCNT_W-1:0] qcnt_q;
  logic [blg_pkg::PCT_W-1:0]  pct_base_q;
  logic [blg_pkg::PCT_W-1:0]  pct_q;
  logic [blg_pkg::MV_W-1:0]   out_mv_q;
  logic [blg_pkg::PCT_W-1:0]  out_pct_q;

  logic [blg_pkg::MEAN_PROD_W-1:0]  mean_prod;
  logic [blg_pkg::SCALE_PROD_W-1:0] scale_prod;
  logic [blg_pkg::MV_WIDE_W-1:0]    mv_wide;
  logic [blg_pkg::MV_W-1:0]         mv_sat;
  logic [blg_pkg::IDX_W-1:0]        idx_prev;
  logic [blg_pkg::MV_W-1:0]         offset;
  logic [blg_pkg::MV_W-1:0]         step_mv;
  logic [blg_pkg::PCT_W-1:0]        step_pct;
  logic                             rem_ge;
  logic [blg_pkg::QBITS-1:0]        quot_d;

  // ---- group accumulation and scale register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= blg_pkg::SCALE_RESET;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        sum_q <= sum_q + blg_pkg::SUM_W'(adc_sample_i);
        if (!stat_o.group_last) count_q <= count_q + 1'b1;
      end
      if (cmd_i.mean) begin
        sum_q   <= '0;
        count_q <= '0;
      end
    end
  end

  // ---- arithmetic ----
  assign mean_prod  = blg_pkg::MEAN_PROD_W'(sum_q)
                    * blg_pkg::MEAN_PROD_W'(blg_pkg::MEAN_RECIP);
  assign scale_prod = blg_pkg::SCALE_PROD_W'(mean_q) * blg_pkg::SCALE_PROD_W'(scale_q);
  assign mv_wide    = scale_prod[blg_pkg::SCALE_PROD_W-1:blg_pkg::SCALE_FRAC];
  assign mv_sat     = (|mv_wide[blg_pkg::MV_WIDE_W-1:blg_pkg::MV_W]) ? blg_pkg::MV_MAX
                    : mv_wide[blg_pkg::MV_W-1:0];

  assign idx_prev = idx_q - 1'b1;
  assign offset   = mv_q - blg_pkg::CURVE_MV[idx_prev];
  assign step_mv  = blg_pkg::CURVE_MV[idx_q] - blg_pkg::CURVE_MV[idx_prev];
  assign step_pct = blg_pkg::CURVE_PCT[idx_q] - blg_pkg::CURVE_PCT[idx_prev];

  assign rem_ge = rem_q >= div_q;
  assign quot_d = {quot_q[blg_pkg::QBITS-2:0], rem_ge};

  assign stat_o.group_last = count_q == blg_pkg::CNT_W'(blg_pkg::SAMPLES - 1);
  assign stat_o.mv_low     = mv_q <= blg_pkg::CURVE_MV[0];
  assign stat_o.mv_high    = mv_q >= blg_pkg::CURVE_MV[blg_pkg::TABLE_POINTS-1];
  assign stat_o.scan_hit   = mv_q <= blg_pkg::CURVE_MV[idx_q];
  assign stat_o.div_last   = qcnt_q == '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean) mean_q <= mean_prod[blg_pkg::MEAN_SHIFT +: blg_pkg::ADC_W];
    if (cmd_i.scale) begin
      mv_q  <= mv_sat;
      idx_q <= blg_pkg::IDX_W'(1);
    end
    if (cmd_i.scan) begin
      if (stat_o.mv_low) begin
        pct_q <= blg_pkg::PCT_NONE;
      end else if (stat_o.mv_high) begin
        pct_q <= blg_pkg::PCT_FULL;
      end else if (!stat_o.scan_hit) begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (cmd_i.product) begin
      rem_q      <= blg_pkg::NUM_W'(step_pct) * blg_pkg::NUM_W'(offset);
      div_q      <= blg_pkg::NUM_W'(step_mv) << (blg_pkg::QBITS - 1);
      quot_q     <= '0;
      qcnt_q     <= blg_pkg::QCNT_W'(blg_pkg::QBITS - 1);
      pct_base_q <= blg_pkg::CURVE_PCT[idx_prev];
    end
    if (cmd_i.divide) begin
      // one quotient bit per cycle, most significant first
      if (rem_ge) rem_q <= rem_q - div_q;
      div_q  <= div_q >> 1;
      quot_q <= quot_d;
      qcnt_q <= qcnt_q - 1'b1;
      if (stat_o.div_last) pct_q <= pct_base_q + quot_d;
    end
    if (cmd_i.emit) begin
      out_mv_q  <= mv_q;
      out_pct_q <= pct_q;
    end
  end

  assign battery_mv_o     = out_mv_q;
  assign charge_percent_o = out_pct_q;

  `BLG_ASSERT_IMP(a_scan_index_in_curve, cmd_i.scan, idx_q != '0 && idx_q <= blg_pkg::IDX_W'(blg_pkg::TABLE_POINTS - 1), "curve scan index out of range")
  `BLG_ASSERT_NXT(a_percent_in_range, cmd_i.emit, charge_percent_o <= blg_pkg::PCT_FULL, "charge percent above full")

endmodule

### hw/rtl/battery_level_gauge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// battery_level_gauge
// Averages groups of converter samples, scales the mean to millivolts and
// maps it to a charge percentage over a piecewise-linear discharge curve.
// ---------------------------------------------------------------------------
//  channel    dir   handshake     payload
//  sample_i   in    valid/ready   adc_sample[11:0]
//  result_o   out   valid/ready   battery_mv[12:0], charge_percent[6:0]
//  cfg        in    cfg_we_i      cfg_wdata_i[17:0] (mv_scale_q16)
//
//  idle, a valid sample is taken at once; only the last sample of a group starts work
//  the group word goes through mean, scaling and the curve scan, which steps point by
//  point; off the curve ends the product and the 7-step restoring divide follow; the
//  word is presented once the result side has taken any earlier word
//  no sample is taken while a group result is in work; a waiting result word
//  does not block the next samples, only the next group's emit
//  reset clears the open group and loads the default scale factor
// ---------------------------------------------------------------------------
module battery_level_gauge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [blg_pkg::SCALE_W-1:0] cfg_wdata_i,
  blg_in_if.sink                      sample_i,
  blg_out_if.source                   result_o
);

  blg_pkg::blg_cmd_t  cmd;
  blg_pkg::blg_stat_t stat;

  blg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  blg_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .adc_sample_i     (sample_i.adc_sample),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .battery_mv_o     (result_o.battery_mv),
    .charge_percent_o (result_o.charge_percent)
  );

endmodule

### bench/tb_battery_level_gauge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_battery_level_gauge
// Self-checking bench for the battery level gauge. Converter samples go in
// over valid/ready in whole groups, with random idling on both sides and one
// long hold-off on the result side. A model of the averaging, the Q16 scaling
// and the curve lookup predicts the group readings not typed into the directed table, and each result word is
// compared in order against it. The scale factor is changed between phases,
// including zero and full scale.
// ---------------------------------------------------------------------------
module tb_battery_level_gauge;

  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned RANDOM_SAMPLES  = 1150;
  localparam int unsigned HOLD_OFF_AT     = 60;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned DIRECTED_ROWS   = 25;

  localparam logic [blg_pkg::SCALE_W-1:0] SCALE_UNITY = 18'd65536;
  localparam logic [blg_pkg::SCALE_W-1:0] SCALE_TOP   = {blg_pkg::SCALE_W{1'b1}};
  localparam logic [blg_pkg::ADC_W-1:0]   ADC_TOP     = {blg_pkg::ADC_W{1'b1}};

  typedef struct packed {
    logic [blg_pkg::MV_W-1:0]  mv;
    logic [blg_pkg::PCT_W-1:0] pct;
  } gauge_reading_t;

  typedef struct packed {
    bit                          load;
    logic [blg_pkg::SCALE_W-1:0] scale;
    logic [blg_pkg::ADC_W-1:0]   adc_value;
    bit                          known;
    logic [blg_pkg::MV_W-1:0]    mv;
    logic [blg_pkg::PCT_W-1:0]   pct;
  } sample_row_t;

  // whole groups only; a reading may be typed in on the last word of a group
  sample_row_t sample_table [DIRECTED_ROWS] = '{
    '{1'b0, blg_pkg::SCALE_RESET, 12'd0,    1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd0,    1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd0,    1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd0,    1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd0,    1'b1, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, blg_pkg::SCALE_RESET, 12'd4095, 1'b1, 13'd5838, 7'd100},
    '{1'b1, SCALE_TOP,            12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_TOP,            12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_TOP,            12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_TOP,            12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_TOP,            12'd4095, 1'b1, 13'd8191, 7'd100},
    '{1'b1, 18'd0,                12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, 18'd0,                12'd0,    1'b0, 13'd0,    7'd0},
    '{1'b0, 18'd0,                12'd4095, 1'b0, 13'd0,    7'd0},
    '{1'b0, 18'd0,                12'd0,    1'b0, 13'd0,    7'd0},
    '{1'b0, 18'd0,                12'd1,    1'b1, 13'd0,    7'd0},
    '{1'b1, SCALE_UNITY,          12'd3611, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_UNITY,          12'd3700, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_UNITY,          12'd3790, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_UNITY,          12'd3800, 1'b0, 13'd0,    7'd0},
    '{1'b0, SCALE_UNITY,          12'd3900, 1'b0, 13'd0,    7'd0}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [blg_pkg::SCALE_W-1:0] cfg_wdata_i;

  blg_in_if  sample_if ();
  blg_out_if result_if ();

  battery_level_gauge dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .sample_i   (sample_if),
    .result_o   (result_if)
  );

  always #2 clk_i = ~clk_i;

  // gauge model state
  logic [blg_pkg::SCALE_W-1:0] scale_q16;
  logic [blg_pkg::SUM_W-1:0]   open_sum;
  logic [blg_pkg::CNT_W-1:0]   open_count;
  gauge_reading_t              pending_readings [$];
  int unsigned                 mismatches;
  int unsigned                 words_seen;

  function automatic logic [blg_pkg::PCT_W-1:0] charge_of(
      input logic [blg_pkg::MV_W-1:0] mv);
    int unsigned lo_mv, step_mv, step_pct;
    if (mv <= blg_pkg::CURVE_MV[0]) return blg_pkg::PCT_NONE;
    if (mv >= blg_pkg::CURVE_MV[blg_pkg::TABLE_POINTS-1]) return blg_pkg::PCT_FULL;
    for (int i = 1; i < blg_pkg::TABLE_POINTS; i++) begin
      if (mv <= blg_pkg::CURVE_MV[i]) begin
        lo_mv    = blg_pkg::CURVE_MV[i-1];
        step_mv  = blg_pkg::CURVE_MV[i] - lo_mv;
        step_pct = blg_pkg::CURVE_PCT[i] - blg_pkg::CURVE_PCT[i-1];
        if (step_mv == 0) return blg_pkg::CURVE_PCT[i];
        return blg_pkg::PCT_W'(blg_pkg::CURVE_PCT[i-1]
                               + (step_pct * (mv - lo_mv)) / step_mv);
      end
    end
    return blg_pkg::PCT_FULL;
  endfunction

  // folds one word into the open group; returns 1 when the group closes
  function automatic bit absorb_sample(input logic [blg_pkg::ADC_W-1:0] adc_value,
                                       output gauge_reading_t reading);
    int unsigned     mean;
    longint unsigned scaled;
    reading    = '0;
    open_sum   = open_sum + blg_pkg::SUM_W'(adc_value);
    open_count = open_count + 1'b1;
    if (open_count < blg_pkg::SAMPLES) return 1'b0;
    mean       = open_sum / blg_pkg::SAMPLES;
    open_sum   = '0;
    open_count = '0;
    scaled     = (64'(mean) * 64'(scale_q16)) >> blg_pkg::SCALE_FRAC;
    reading.mv  = (scaled > blg_pkg::MV_MAX) ? blg_pkg::MV_MAX : blg_pkg::MV_W'(scaled);
    reading.pct = charge_of(reading.mv);
    return 1'b1;
  endfunction

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [blg_pkg::ADC_W-1:0] sample_near(input int unsigned base);
    int v;
    v = int'(base) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > int'(ADC_TOP)) v = int'(ADC_TOP);
    return blg_pkg::ADC_W'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  task automatic check_reading(input logic [blg_pkg::MV_W-1:0] mv,
                               input logic [blg_pkg::PCT_W-1:0] pct);
    gauge_reading_t want;
    if (pending_readings.size() == 0) begin
      report_mismatch($sformatf("word mv=%0d pct=%0d with no group pending", mv, pct));
    end else begin
      want = pending_readings.pop_front();
      if (mv !== want.mv)
        report_mismatch($sformatf("battery_mv %0d, want %0d", mv, want.mv));
      if (pct !== want.pct)
        report_mismatch($sformatf("charge_percent %0d, want %0d (mv %0d)", pct, want.pct,
                                  want.mv));
    end
  endtask

  // only between groups, once every reading is out and the block has settled
  task automatic load_scale(input logic [blg_pkg::SCALE_W-1:0] value);
    sample_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    scale_q16 = value;
  endtask

  task automatic push_sample(input logic [blg_pkg::ADC_W-1:0] adc_value, input bit steady,
                             output bit closed, output gauge_reading_t reading);
    int unsigned gap;
    gap = steady ? 0 : idle_cycles();
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_if.valid      <= 1'b1;
    sample_if.adc_sample <= adc_value;
    @(posedge clk_i);
    while (sample_if.ready !== 1'b1) @(posedge clk_i);
    closed = absorb_sample(adc_value, reading);
  endtask

  initial begin : stimulus
    gauge_reading_t              reading;
    bit                          closed, steady;
    int unsigned                 sent, groups, kind, base;
    logic [blg_pkg::SCALE_W-1:0] next_scale;
    logic [blg_pkg::ADC_W-1:0]   adc_value;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    sample_if.valid      <= 1'b0;
    sample_if.adc_sample <= '0;
    scale_q16  = blg_pkg::SCALE_RESET;
    open_sum   = '0;
    open_count = '0;
    mismatches = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (sample_table[i]) begin
      if (sample_table[i].load) load_scale(sample_table[i].scale);
      push_sample(sample_table[i].adc_value, 1'b0, closed, reading);
      if (closed) begin
        if (sample_table[i].known) begin
          reading.mv  = sample_table[i].mv;
          reading.pct = sample_table[i].pct;
        end
        pending_readings.push_back(reading);
      end
    end

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 7)) inside
        0:       next_scale = blg_pkg::SCALE_RESET;
        1:       next_scale = SCALE_UNITY;
        [2:3]:   next_scale = blg_pkg::SCALE_W'($urandom_range(80000, 110000));
        4:       next_scale = blg_pkg::SCALE_W'($urandom);
        5:       next_scale = '0;
        6:       next_scale = SCALE_TOP;
        default: next_scale = blg_pkg::SCALE_W'($urandom_range(110001, 262143));
      endcase
      load_scale(next_scale);
      steady = ($urandom_range(0, 3) == 0);
      groups = $urandom_range(3, 25);
      repeat (groups) begin
        kind = $urandom_range(0, 9);
        // aim the group mean at a millivolt target on or around the curve, or at a random base
        if (scale_q16 == 0 || kind == 9)
          base = $urandom_range(0, ADC_TOP);
        else if (kind == 6)
          base = ((int'(blg_pkg::CURVE_MV[$urandom_range(0, blg_pkg::TABLE_POINTS-1)])
                   << blg_pkg::SCALE_FRAC) + scale_q16 - 1) / scale_q16;
        else
          base = (($urandom_range(3200, 4260) << blg_pkg::SCALE_FRAC) + scale_q16 - 1)
                 / scale_q16;
        if (base > 32'(ADC_TOP)) base = 32'(ADC_TOP);
        for (int k = 0; k < blg_pkg::SAMPLES; k++) begin
          case (kind) inside
            6, 9:    adc_value = blg_pkg::ADC_W'(base);
            7:       adc_value = blg_pkg::ADC_W'($urandom);
            8:       adc_value = $urandom_range(0, 1) ? ADC_TOP : '0;
            default: adc_value = sample_near(base);
          endcase
          push_sample(adc_value, steady, closed, reading);
          if (closed) pending_readings.push_back(reading);
          sent++;
        end
      end
    end

    sample_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_battery_level_gauge: done, clean");
    else
      $display("tb_battery_level_gauge: done, errors");
    $finish;
  end

  initial begin : result_sink
    int unsigned gap, calm;
    bit          held;
    result_if.ready <= 1'b0;
    words_seen = 0;
    calm       = 0;
    held       = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && words_seen == HOLD_OFF_AT) begin
        // long back-pressure so the block fills and stalls its input
        held = 1'b1;
        gap  = HOLD_OFF_CYCLES;
      end else if (calm != 0) begin
        calm--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 30);
        gap = idle_cycles();
      end
      if (gap != 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      @(posedge clk_i);
      while (result_if.valid !== 1'b1) @(posedge clk_i);
      check_reading(result_if.battery_mv, result_if.charge_percent);
      words_seen++;
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb_battery_level_gauge: done, errors");
    $finish;
  end

endmodule
